// ===== design/assert_macros.svh =====
// Assertion helpers used by page_frame_replacement
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Types and constants shared by the page frame replacement block.
// ----------------------------------------------------------------------------
`default_nettype none
package pfr_pkg;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_LRU  = 2'd1;
	localparam logic [1:0] POL_LFU  = 2'd2;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Hit, empty slot and best candidate passed along the chain of frame cells
	typedef struct packed {
		logic        hit_found;
		logic [5:0]  hit_idx;
		logic        empty_found;
		logic [5:0]  empty_idx;
		logic        best_found;
		logic [5:0]  best_idx;
		logic [31:0] best_key;
		logic [31:0] best_tie;
		logic [7:0]  best_page;
	} scan_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == SAT32) ? v : v + 32'd1;
	endfunction
endpackage
`default_nettype wire

// ===== design/pfr_cell.sv =====
// ----------------------------------------------------------------------------
// pfr_cell
// One frame: holds page and stamps, folds itself into the passing scan word.
// ----------------------------------------------------------------------------
`default_nettype none
module pfr_cell
	import pfr_pkg::*;
#(
	parameter int unsigned IDX_W = 3,
	parameter int unsigned PAGE_W = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [IDX_W-1:0]  my_idx,
	input  wire logic              active,
	input  wire logic [PAGE_W-1:0] page,
	input  wire logic [1:0]        policy,
	input  wire logic [31:0]       page_cnt,
	input  wire scan_t             scan_in,
	output scan_t                  scan_out,
	output logic [PAGE_W-1:0]      cur_page,
	input  wire logic              clr,
	input  wire logic              wr_hit,
	input  wire logic              wr_load,
	input  wire logic [31:0]       now
);
	logic              valid_q;
	logic [PAGE_W-1:0] page_q;
	logic [31:0]       load_q;
	logic [31:0]       last_q;
	logic [31:0]       key;
	logic [31:0]       tie;
	logic              better;

	assign cur_page = page_q;

	always_comb begin
		case (policy)
			POL_LRU: begin
				key = last_q;
				tie = 32'd0;
			end
			POL_LFU: begin
				key = page_cnt;
				tie = last_q;
			end
			default: begin
				key = load_q;
				tie = 32'd0;
			end
		endcase
		better = !scan_in.best_found || key < scan_in.best_key ||
			(key == scan_in.best_key && tie < scan_in.best_tie);
		scan_out = scan_in;
		if (active) begin
			if (valid_q && page_q == page && !scan_in.hit_found) begin
				scan_out.hit_found = 1'b1;
				scan_out.hit_idx = 6'(my_idx);
			end
			if (!valid_q && !scan_in.empty_found) begin
				scan_out.empty_found = 1'b1;
				scan_out.empty_idx = 6'(my_idx);
			end
			if (better) begin
				scan_out.best_found = 1'b1;
				scan_out.best_idx = 6'(my_idx);
				scan_out.best_key = key;
				scan_out.best_tie = tie;
				scan_out.best_page = 8'(page_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			page_q <= '0;
			load_q <= '0;
			last_q <= '0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr_load) begin
			valid_q <= 1'b1;
			page_q <= page;
			load_q <= now;
			last_q <= now;
		end else if (wr_hit) begin
			last_q <= now;
		end
	end
endmodule
`default_nettype wire

// ===== design/page_frame_replacement.sv =====
// An accepted page is registered and scanned through the frame cells in ST_SCAN; the result
// is registered and held in ST_DONE until taken; one item at a time.
// A new reference is accepted only in ST_IDLE, after the previous result is taken.
// The scan word moves one frame cell per cycle.
// Reset clears all frames, use counts, time and fault counters at once;
// policy resets to FIFO and frames_q to 8.
`default_nettype none
module page_frame_replacement
	import pfr_pkg::*;
#(
	parameter int unsigned FRAMES = 8,
	parameter int unsigned PAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  page,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic [2:0]       frame,
	output logic             evicted_valid,
	output logic [3:0]       evicted_page,
	output logic [31:0]      fault_count
);
	`include "assert_macros.svh"

	localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned PG_W = $clog2(PAGES);
	localparam int unsigned STEP_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	state_t state_q, state_d;
	logic [1:0]      policy_q;
	logic [3:0]      frames_q;
	logic [PG_W-1:0] page_q;
	logic [31:0]     now_q;
	logic [31:0]     faults_q;
	logic [31:0]     cnt_q [PAGES];
	logic [6:0]      active_n;
	logic [STEP_W-1:0] step_q;
	logic            last_step;
	scan_t           chain [FRAMES];
	scan_t           res_s2;
	logic [PG_W-1:0] cpage [FRAMES];
	logic            accept_in;
	logic            do_update;

	assign cfg_ready = (state_q == ST_IDLE);
	assign accept_in = in_valid && in_ready;
	assign last_step = (step_q == STEP_W'(FRAMES - 1));

	always_comb begin
		if (frames_q == 4'd0) active_n = 7'd1;
		else if (7'(frames_q) > 7'(FRAMES)) active_n = 7'(FRAMES);
		else active_n = 7'(frames_q);
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		do_update = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_step) begin
					do_update = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
	assign out_valid = (state_q == ST_DONE);

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		logic wl;
		scan_t prev;
		if (g == 0) begin : g_head
			assign prev = '0;
		end else begin : g_link
			scan_t link_q;
			// advance the scan word one cell per cycle
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) link_q <= '0;
				else link_q <= chain[g-1];
			end
			assign prev = link_q;
		end
		assign wl = do_update && !chain[FRAMES-1].hit_found &&
			(chain[FRAMES-1].empty_found ? chain[FRAMES-1].empty_idx == 6'(g)
				: chain[FRAMES-1].best_idx == 6'(g));
		pfr_cell #(.IDX_W(IDX_W), .PAGE_W(PG_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .my_idx(IDX_W'(g)),
			.active(7'(g) < active_n), .page(page_q), .policy(policy_q),
			.page_cnt(cnt_q[cpage[g]]), .scan_in(prev), .scan_out(chain[g]),
			.cur_page(cpage[g]), .clr(1'b0),
			.wr_hit(do_update && chain[FRAMES-1].hit_found &&
				chain[FRAMES-1].hit_idx == 6'(g)),
			.wr_load(wl), .now(now_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POL_FIFO;
			frames_q <= 4'd8;
			now_q <= '0;
			faults_q <= '0;
			step_q <= '0;
			for (int i = 0; i < PAGES; i++) cnt_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN && !last_step) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_POLICY) policy_q <= cfg_data[1:0];
				else frames_q <= cfg_data;
			end
			if (accept_in) begin
				now_q <= sat_inc(now_q);
				cnt_q[PG_W'(page)] <= sat_inc(cnt_q[PG_W'(page)]);
			end
			if (do_update && !chain[FRAMES-1].hit_found) faults_q <= sat_inc(faults_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) page_q <= PG_W'(page);
		if (do_update) res_s2 <= chain[FRAMES-1];
	end

	assign hit = res_s2.hit_found;
	assign frame = res_s2.hit_found ? 3'(res_s2.hit_idx) :
		res_s2.empty_found ? 3'(res_s2.empty_idx) : 3'(res_s2.best_idx);
	assign evicted_valid = !res_s2.hit_found && !res_s2.empty_found;
	assign evicted_page = evicted_valid ? 4'(res_s2.best_page) : 4'd0;
	assign fault_count = faults_q;

	`ASSERT_NEXT(a_scan_done, clk, arst_n, state_q == ST_SCAN && last_step, out_valid, "scan must finish")
	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, out_valid, !in_ready, "input taken while busy")
	`ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && !out_ready, out_valid && $stable(frame),
		"result dropped")
endmodule
`default_nettype wire
